/* src/ssl_pkg.sv */
package ssl_pkg;

   localparam int SHORT_DEPTH = 64;
   localparam int LONG_DEPTH = 1024;
   localparam int SHORT_AW = $clog2(SHORT_DEPTH);
   localparam int LONG_AW = $clog2(LONG_DEPTH);
   localparam int CLR_DEPTH = (LONG_DEPTH > SHORT_DEPTH) ? LONG_DEPTH : SHORT_DEPTH;
   localparam int CLR_AW = $clog2(CLR_DEPTH);

   localparam int BYTE_W = 8;
   localparam int ADDR_W = 10;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_HDR2 = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   typedef struct packed {
      logic              data;
      logic              is_long;
      logic              is_write;
      logic [ADDR_W-1:0] addr;
   } access_type;

endpackage

/* src/ssl_ram.sv */
module ssl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ssl_frame.sv */
module ssl_frame (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             mosi_byte,
   input  logic                   frame_start,
   output ssl_pkg::access_type    access
);

   ssl_pkg::phase_type              phase_ff, phase_in;
   logic                            is_long_ff, is_long_in;
   logic                            is_write_ff, is_write_in;
   logic [ssl_pkg::ADDR_W-1:0]      addr_ff, addr_in;

   always_comb begin
      access.data = !frame_start && (phase_ff == ssl_pkg::PH_DATA);
      access.is_long = is_long_ff;
      access.is_write = is_write_ff;
      access.addr = addr_ff;
   end

   always_comb begin
      phase_in = phase_ff;
      is_long_in = is_long_ff;
      is_write_in = is_write_ff;
      addr_in = addr_ff;
      if (frame_start) begin
         if (!mosi_byte[7]) begin
            is_long_in = 1'b0;
            addr_in = {4'b0000, mosi_byte[6:1]};
            is_write_in = mosi_byte[0];
            phase_in = ssl_pkg::PH_DATA;
         end else begin
            is_long_in = 1'b1;
            is_write_in = 1'b0;
            addr_in = {mosi_byte[6:0], 3'b000};
            phase_in = ssl_pkg::PH_HDR2;
         end
      end else begin
         unique case (phase_ff)
            ssl_pkg::PH_HDR2: begin
               addr_in = {addr_ff[9:3], mosi_byte[7:5]};
               is_write_in = mosi_byte[4];
               phase_in = ssl_pkg::PH_DATA;
            end
            ssl_pkg::PH_DATA: begin
               if (is_long_ff) begin
                  addr_in = addr_ff + 10'd1;
               end
            end
            ssl_pkg::PH_IDLE: begin
               phase_in = ssl_pkg::PH_IDLE;
            end
            default: begin
               phase_in = ssl_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ssl_pkg::PH_IDLE;
         is_long_ff <= 1'b0;
         is_write_ff <= 1'b0;
         addr_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         is_long_ff <= is_long_in;
         is_write_ff <= is_write_in;
         addr_ff <= addr_in;
      end
   end

endmodule

/* src/spi_short_long_register_slave.sv */
// Register interface behind an SPI slave, one SPI byte per request.
// A request is taken at a rising edge where start is high and busy is low;
// it carries the byte from the master and a flag for the first byte of a
// frame. Header bytes select a short (6-bit) or long (10-bit) address and
// the direction; data bytes write or read the short or the long store, and
// long accesses step the address after each data byte.
// Every request gives exactly one response, in the cycle after it is taken:
// rsp_strobe is high for that single cycle with the read byte, the data
// flag and the address used. The receiver cannot hold responses off.
// Busy stays high in the cycle after each request, while the store read
// completes and the response is out, so no new request is taken while the
// response to the last one is out.
// After reset both stores are swept to zero, one entry per cycle, for
// CLR_DEPTH entries (1024 at the default depths); busy is high meanwhile.
module spi_short_long_register_slave (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_mosi_byte,
   input  logic        req_frame_start,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_miso_byte,
   output logic        rsp_data_done,
   output logic [9:0]  rsp_access_address
);

   localparam int SAW = ssl_pkg::SHORT_AW;
   localparam int LAW = ssl_pkg::LONG_AW;
   localparam int CAW = ssl_pkg::CLR_AW;

   ssl_pkg::access_type   access;
   logic                  accept;
   logic                  in_range;
   logic                  short_hit, long_hit;

   logic                  clearing_ff;
   logic [CAW-1:0]        clr_addr_ff;
   logic                  pend_ff;
   logic                  rd_short_ff, rd_long_ff;
   logic                  done_ff;
   logic [9:0]            addr_ff;

   logic                  short_we, long_we;
   logic [SAW-1:0]        short_waddr;
   logic [LAW-1:0]        long_waddr;
   logic [7:0]            short_wdata, long_wdata;
   logic [7:0]            short_rdata, long_rdata;

   assign busy = clearing_ff | pend_ff;
   assign accept = start & !busy;

   ssl_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mosi_byte   (req_mosi_byte),
      .frame_start (req_frame_start),
      .access      (access)
   );

   always_comb begin
      if (access.is_long) begin
         in_range = {1'b0, access.addr} < 11'(ssl_pkg::LONG_DEPTH);
      end else begin
         in_range = {1'b0, access.addr} < 11'(ssl_pkg::SHORT_DEPTH);
      end
      short_hit = access.data & in_range & !access.is_long;
      long_hit = access.data & in_range & access.is_long;
   end

   always_comb begin
      if (clearing_ff) begin
         short_we = {1'b0, clr_addr_ff} < (CAW + 1)'(ssl_pkg::SHORT_DEPTH);
         long_we = {1'b0, clr_addr_ff} < (CAW + 1)'(ssl_pkg::LONG_DEPTH);
         short_waddr = clr_addr_ff[SAW-1:0];
         long_waddr = clr_addr_ff[LAW-1:0];
         short_wdata = '0;
         long_wdata = '0;
      end else begin
         short_we = accept & short_hit & access.is_write;
         long_we = accept & long_hit & access.is_write;
         short_waddr = access.addr[SAW-1:0];
         long_waddr = access.addr[LAW-1:0];
         short_wdata = req_mosi_byte;
         long_wdata = req_mosi_byte;
      end
   end

   ssl_ram #(
      .WIDTH (8),
      .DEPTH (ssl_pkg::SHORT_DEPTH)
   ) u_short_ram (
      .clock   (clock),
      .wr_en   (short_we),
      .wr_addr (short_waddr),
      .wr_data (short_wdata),
      .rd_addr (access.addr[SAW-1:0]),
      .rd_data (short_rdata)
   );

   ssl_ram #(
      .WIDTH (8),
      .DEPTH (ssl_pkg::LONG_DEPTH)
   ) u_long_ram (
      .clock   (clock),
      .wr_en   (long_we),
      .wr_addr (long_waddr),
      .wr_data (long_wdata),
      .rd_addr (access.addr[LAW-1:0]),
      .rd_data (long_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == CAW'(ssl_pkg::CLR_DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         pend_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_short_ff <= short_hit & !access.is_write;
         rd_long_ff <= long_hit & !access.is_write;
         done_ff <= access.data;
         addr_ff <= access.data ? access.addr : 10'd0;
      end
   end

   assign rsp_strobe = pend_ff;
   assign rsp_data_done = done_ff;
   assign rsp_access_address = addr_ff;
   assign rsp_miso_byte = rd_long_ff ? long_rdata : (rd_short_ff ? short_rdata : 8'd0);

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("Accepted request gave no response in the next cycle.");

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept) && !accept)
      else $error("Response without a request, or a request taken during a response.");

   a_header_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data_done) |-> (rsp_miso_byte == 8'd0 && rsp_access_address == 10'd0))
      else $error("Header or idle byte produced a nonzero response.");

   a_clear_blocks: assert property (@(posedge clock)
      $fell(reset) |-> busy && clearing_ff)
      else $error("Store clearing did not hold off requests after reset.");

endmodule

/* test/tb_spi_short_long_register_slave.sv */
`timescale 1ns / 1ps

module tb_spi_short_long_register_slave;

   localparam int TOTAL_REQUESTS = 1450;
   localparam int RSP_LATENCY = 1;
   localparam int DRAIN_LIMIT = 200;
   localparam logic [7:0] RX_FIFO_HEADER = 8'hE0;

   typedef struct packed {
      logic [7:0] miso;
      logic       done;
      logic [9:0] addr;
   } spi_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [7:0] req_mosi_byte = 8'h00;
   logic       req_frame_start = 1'b0;
   logic       rsp_strobe;
   logic [7:0] rsp_miso_byte;
   logic       rsp_data_done;
   logic [9:0] rsp_access_address;

   ssl_pkg::phase_type acc_phase = ssl_pkg::PH_IDLE;
   logic        acc_long = 1'b0;
   logic        acc_write = 1'b0;
   logic [9:0]  acc_addr = '0;
   logic [7:0]  short_mem [ssl_pkg::SHORT_DEPTH];
   logic [7:0]  long_mem [ssl_pkg::LONG_DEPTH];
   spi_rsp_type pending_responses [$];
   spi_rsp_type head_rsp;

   int n_requests = 0;
   int n_reads = 0;
   int n_data_checked = 0;
   int n_errors = 0;
   int burst_left = 0;

   spi_short_long_register_slave i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mosi_byte      (req_mosi_byte),
      .req_frame_start    (req_frame_start),
      .rsp_strobe         (rsp_strobe),
      .rsp_miso_byte      (rsp_miso_byte),
      .rsp_data_done      (rsp_data_done),
      .rsp_access_address (rsp_access_address)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("tb_spi_short_long_register_slave NOT OK");
      $finish;
   end

   function automatic void predict_register_access(input logic [7:0] b, input logic fs);
      spi_rsp_type r;
      r = '0;
      if (fs) begin
         if (!b[7]) begin
            acc_long = 1'b0;
            acc_addr = {4'd0, b[6:1]};
            acc_write = b[0];
            acc_phase = ssl_pkg::PH_DATA;
         end else begin
            acc_long = 1'b1;
            acc_write = 1'b0;
            acc_addr = {b[6:0], 3'b000};
            acc_phase = ssl_pkg::PH_HDR2;
         end
      end else if (acc_phase == ssl_pkg::PH_HDR2) begin
         acc_addr[2:0] = b[7:5];
         acc_write = b[4];
         acc_phase = ssl_pkg::PH_DATA;
      end else if (acc_phase == ssl_pkg::PH_DATA) begin
         r.done = 1'b1;
         r.addr = acc_addr;
         if (!acc_write) n_reads++;
         if (acc_long) begin
            if (int'(acc_addr) < ssl_pkg::LONG_DEPTH) begin
               if (acc_write) long_mem[acc_addr] = b;
               else r.miso = long_mem[acc_addr];
            end
            acc_addr = acc_addr + 10'd1;
         end else begin
            if (int'(acc_addr) < ssl_pkg::SHORT_DEPTH) begin
               if (acc_write) short_mem[acc_addr] = b;
               else r.miso = short_mem[acc_addr];
            end
         end
      end
      pending_responses.push_back(r);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_responses.size() == 0) begin
            $error("Response arrived with no request outstanding.");
            n_errors++;
         end else begin
            head_rsp = pending_responses.pop_front();
            if (rsp_miso_byte !== head_rsp.miso) begin
               $error("miso_byte: expected %02h, got %02h", head_rsp.miso, rsp_miso_byte);
               n_errors++;
            end
            if (rsp_data_done !== head_rsp.done) begin
               $error("data_done: expected %0b, got %0b", head_rsp.done, rsp_data_done);
               n_errors++;
            end
            if (rsp_access_address !== head_rsp.addr) begin
               $error("access_address: expected %03h, got %03h", head_rsp.addr,
                      rsp_access_address);
               n_errors++;
            end
            if (head_rsp.done) n_data_checked++;
         end
      end
   end

   task automatic send_request(input logic [7:0] b, input logic fs);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_mosi_byte <= b;
      req_frame_start <= fs;
      start <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_register_access(b, fs);
      n_requests++;
   endtask

   task automatic drain_responses();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (pending_responses.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (RSP_LATENCY + 2) @(posedge clock);
   endtask

   task automatic send_frame(input logic is_long_frame, input logic wr, input logic [9:0] addr,
                             input int n_data);
      if (is_long_frame) begin
         send_request({1'b1, addr[9:3]}, 1'b1);
         send_request({addr[2:0], wr, 4'($urandom)}, 1'b0);
      end else begin
         send_request({1'b0, addr[5:0], wr}, 1'b1);
      end
      repeat (n_data) send_request(8'($urandom), 1'b0);
   endtask

   task automatic test_idle_bytes();
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b0);
   endtask

   task automatic test_short_access();
      send_request(8'h7F, 1'b1);
      send_request(8'hA5, 1'b0);
      send_request(8'h5A, 1'b0);
      send_request(8'h7E, 1'b1);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h01, 1'b1);
      send_request(8'hFF, 1'b0);
   endtask

   task automatic test_long_access_wrap();
      send_request(8'hFF, 1'b1);
      send_request(8'hF0, 1'b0);
      send_request(8'h3C, 1'b0);
      send_request(8'hC3, 1'b0);
      send_request(8'hFF, 1'b1);
      send_request(8'hE0, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'h00, 1'b0);
   endtask

   task automatic test_rx_fifo_burst();
      send_request(RX_FIFO_HEADER, 1'b1);
      send_request(8'h00, 1'b0);
      send_request(8'h00, 1'b0);
   endtask

   task automatic test_frame_restart();
      send_request(8'h80, 1'b1);
      send_request(8'h03, 1'b1);
      send_request(8'h77, 1'b0);
      send_request(8'h02, 1'b1);
      send_request(8'h00, 1'b0);
   endtask

   task automatic test_drain_pause();
      logic [9:0] addr;
      addr = 10'($urandom);
      send_frame(1'b1, 1'b1, addr, 3);
      drain_responses();
      send_frame(1'b1, 1'b0, addr, 3);
   endtask

   task automatic test_random_traffic(input int target);
      int kind;
      logic [9:0] addr;
      while (n_requests < target) begin
         kind = $urandom_range(0, 99);
         case ($urandom_range(0, 3))
            0: addr = 10'($urandom);
            1: addr = 10'h300 + 10'($urandom_range(0, 15));
            2: addr = 10'h3FC + 10'($urandom_range(0, 3));
            default: addr = 10'($urandom_range(0, 15));
         endcase
         if (kind < 72) begin
            if ($urandom_range(0, 1))
               send_frame(1'b1, 1'($urandom), addr, $urandom_range(1, 8));
            else
               send_frame(1'b0, 1'($urandom), {4'd0, 6'($urandom)}, $urandom_range(1, 4));
         end else if (kind < 87) begin
            send_request(8'($urandom), ($urandom_range(0, 3) == 0));
         end else begin
            case ($urandom_range(0, 2))
               0: send_request({1'b1, addr[9:3]}, 1'b1);
               1: send_frame(1'b1, 1'($urandom), addr, 0);
               default: send_frame(1'b0, 1'($urandom), addr, 0);
            endcase
         end
      end
   endtask

   initial begin
      foreach (short_mem[i]) short_mem[i] = 8'h00;
      foreach (long_mem[i]) long_mem[i] = 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_bytes();
      test_short_access();
      test_long_access_wrap();
      test_rx_fifo_burst();
      test_frame_restart();
      test_drain_pause();
      test_random_traffic(TOTAL_REQUESTS / 2);
      drain_responses();
      test_random_traffic(TOTAL_REQUESTS);
      drain_responses();
      if (pending_responses.size() != 0) begin
         $error("%0d expected responses never arrived.", pending_responses.size());
         n_errors++;
      end
      $display("Sent %0d requests over short and long frames; %0d data bytes checked,",
               n_requests, n_data_checked);
      $display("%0d of them reads, with address wrap, RX FIFO bursts and frame restarts.",
               n_reads);
      if (n_errors == 0) begin
         $display("tb_spi_short_long_register_slave OK");
      end else begin
         $display("tb_spi_short_long_register_slave NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
src/ssl_pkg.sv
src/ssl_ram.sv
src/ssl_frame.sv
src/spi_short_long_register_slave.sv
test/tb_spi_short_long_register_slave.sv
